/* hw/rtl/bsf_pkg.sv */
// Brush stamp frame store: shared types and constants.
// Used by every module of the block but the RAM and the queue; depends on nothing.
`default_nettype none

package bsf_pkg;

   // Command codes of one request transaction
   typedef enum logic [1:0] {
      CMD_PAINT = 2'd0,
      CMD_SET   = 2'd1,
      CMD_GET   = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_CANVAS_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_CANVAS_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_CELL_SIZE     = 2'd2;

   localparam int CSR_W   = 7;   // widest register
   localparam int COORD_W = 17;  // centre cell coordinate, signed
   localparam int CELL_W  = 18;  // centre plus brush offset, signed
   localparam int HALF_W  = 4;   // brush half-width
   localparam int OFF_W   = 5;   // signed brush offset
   localparam int SQ_W    = 10;  // squared distances of the round brush
   localparam int COLOR_W = 32;

   localparam logic [COLOR_W-1:0] COLOR_WHITE = 32'hFFFF_FFFF;

   // Classified command handed from the front end to the back end
   typedef struct packed {
      cmd_type                    kind;
      logic signed [COORD_W-1:0]  cx;
      logic signed [COORD_W-1:0]  cy;
      logic [COLOR_W-1:0]         color;
      logic [HALF_W-1:0]          half;
      logic                       brush_round;
   } op_type;

endpackage

`default_nettype wire

/* hw/rtl/bsf_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module bsf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                                       clock,
   input  wire logic                                       we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire logic [WIDTH-1:0]                           wdata,
   output logic      [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end

endmodule

`default_nettype wire

/* hw/rtl/bsf_queue.sv */
// Small first-in first-out queue built from registers.
// No dependencies.
`default_nettype none

module bsf_queue #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  full,
   output logic                  empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/bsf_divider.sv */
// Iterative floor divider: signed pixel distance by unsigned cell size,
// one quotient bit per cycle. Depends on bsf_pkg.
`default_nettype none

module bsf_divider (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic signed [bsf_pkg::COORD_W-1:0]    dividend,
   input  wire logic        [bsf_pkg::CSR_W-1:0]      divisor,
   output logic                                       done,
   output logic signed      [bsf_pkg::COORD_W-1:0]    quotient
);
   import bsf_pkg::*;

   localparam int MAG_W = COORD_W - 1;
   localparam int CNT_W = $clog2(MAG_W);

   typedef enum logic [1:0] {
      D_IDLE,
      D_RUN,
      D_FIX
   } div_state_type;

   div_state_type     state_ff;
   logic              neg_ff;
   logic [MAG_W-1:0]  mag_ff;
   logic [CSR_W-1:0]  rem_ff;
   logic [CSR_W-1:0]  div_ff;
   logic [CNT_W-1:0]  cnt_ff;

   logic [COORD_W-1:0] abs_val;
   logic [CSR_W:0]     trial;
   logic               fits;
   logic [COORD_W-1:0] q_up;

   always_comb begin
      abs_val = dividend[COORD_W-1] ? (~dividend + COORD_W'(1)) : dividend;
      trial   = {rem_ff, mag_ff[MAG_W-1]};
      fits    = (trial >= {1'b0, div_ff});
      q_up    = {1'b0, mag_ff} + COORD_W'(rem_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done     <= 1'b0;
      end else begin
         done <= 1'b0;
         unique case (state_ff)
            D_IDLE: begin
               if (start) begin
                  neg_ff   <= dividend[COORD_W-1];
                  mag_ff   <= abs_val[MAG_W-1:0];
                  rem_ff   <= '0;
                  div_ff   <= divisor;
                  cnt_ff   <= '0;
                  state_ff <= D_RUN;
               end
            end
            D_RUN: begin
               // shift in one dividend bit, subtract where the divisor fits
               rem_ff <= fits ? CSR_W'(trial - {1'b0, div_ff}) : trial[CSR_W-1:0];
               mag_ff <= {mag_ff[MAG_W-2:0], fits};
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(MAG_W - 1)) begin
                  state_ff <= D_FIX;
               end
            end
            D_FIX: begin
               // round towards minus infinity for negative distances
               quotient <= neg_ff ? signed'(~q_up + COORD_W'(1))
                                  : signed'({1'b0, mag_ff});
               done     <= 1'b1;
               state_ff <= D_IDLE;
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/bsf_front.sv */
// Front end: accepts request transactions, maps the pointer to a centre cell
// and queues classified commands. Depends on bsf_pkg and bsf_divider.
`default_nettype none

module bsf_front #(
   parameter int MAX_BRUSH = 31
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               push,
   output logic                                    full,
   input  wire logic [1:0]                         req_command,
   input  wire logic signed [15:0]                 req_pointer_x,
   input  wire logic signed [15:0]                 req_pointer_y,
   input  wire logic signed [15:0]                 req_view_offset_x,
   input  wire logic signed [15:0]                 req_view_offset_y,
   input  wire logic signed [15:0]                 req_cell_x,
   input  wire logic signed [15:0]                 req_cell_y,
   input  wire logic [31:0]                        req_color,
   input  wire logic [4:0]                         req_brush_size,
   input  wire logic                               req_brush_round,
   input  wire logic [bsf_pkg::CSR_W-1:0]          cell_div,
   output logic                                    op_push,
   output bsf_pkg::op_type                         op_out,
   input  wire logic                               op_full
);
   import bsf_pkg::*;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIVX,
      F_DIVY,
      F_PUSH
   } front_state_type;

   front_state_type            state_ff;
   op_type                     op_ff;
   logic signed [COORD_W-1:0]  diff_y_ff;

   logic                       accept;
   cmd_type                    cmd;
   logic signed [COORD_W-1:0]  diff_x, diff_y;
   logic [4:0]                 size_sat;
   logic                       div_start, div_done;
   logic signed [COORD_W-1:0]  div_dividend, div_quotient;

   always_comb begin
      cmd      = cmd_type'(req_command);
      accept   = push && (state_ff == F_IDLE);
      full     = (state_ff != F_IDLE);
      diff_x   = COORD_W'(req_pointer_x) - COORD_W'(req_view_offset_x);
      diff_y   = COORD_W'(req_pointer_y) - COORD_W'(req_view_offset_y);
      size_sat = (32'(req_brush_size) > 32'(MAX_BRUSH)) ? 5'(MAX_BRUSH) : req_brush_size;
      div_start = (accept && cmd == CMD_PAINT) || (state_ff == F_DIVX && div_done);
      div_dividend = (state_ff == F_IDLE) ? diff_x : diff_y_ff;
      op_push  = (state_ff == F_PUSH) && !op_full;
      op_out   = op_ff;
   end

   bsf_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (cell_div),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (accept) begin
                  op_ff.kind  <= cmd;
                  op_ff.color <= req_color;
                  op_ff.cx    <= COORD_W'(req_cell_x);
                  op_ff.cy    <= COORD_W'(req_cell_y);
                  diff_y_ff   <= diff_y;
                  if (cmd == CMD_PAINT) begin
                     op_ff.half        <= size_sat[4:1];
                     op_ff.brush_round <= req_brush_round;
                     state_ff          <= F_DIVX;
                  end else begin
                     // set, get and clear carry no brush; set and get touch the single centre cell
                     op_ff.half        <= '0;
                     op_ff.brush_round <= 1'b0;
                     state_ff          <= F_PUSH;
                  end
               end
            end
            F_DIVX: begin
               if (div_done) begin
                  op_ff.cx <= div_quotient;
                  state_ff <= F_DIVY;
               end
            end
            F_DIVY: begin
               if (div_done) begin
                  op_ff.cy <= div_quotient;
                  state_ff <= F_PUSH;
               end
            end
            F_PUSH: begin
               if (!op_full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/bsf_back.sv */
// Back end: steps through the brush cells, sweeps the store for clear and
// after reset, and queues one result per command. Depends on bsf_pkg, bsf_ram.
`default_nettype none

module bsf_back #(
   parameter int MAX_COLUMNS = 64,
   parameter int MAX_ROWS    = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic [$clog2(MAX_COLUMNS + 1)-1:0]     eff_w,
   input  wire logic [$clog2(MAX_ROWS + 1)-1:0]        eff_h,
   input  wire logic                                   op_empty,
   input  wire bsf_pkg::op_type                        op_in,
   output logic                                        op_pop,
   output logic                                        rsp_push,
   output logic [bsf_pkg::COLOR_W-1:0]                 rsp_data,
   input  wire logic                                   rsp_full,
   output logic                                        init_busy
);
   import bsf_pkg::*;

   localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int XW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int YW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int PW    = XW + YW + 1;

   typedef enum logic [2:0] {
      B_INIT,
      B_IDLE,
      B_RUN,
      B_DRAIN,
      B_CLEAR,
      B_RESULT
   } back_state_type;

   back_state_type            state_ff;
   op_type                    op_ff;
   logic signed [OFF_W-1:0]   dx_ff, dy_ff;
   logic [AW-1:0]             sweep_ff;
   logic [1:0]                drain_ff;
   logic                      s1_valid_ff, s1_we_ff;
   logic [XW-1:0]             s1_x_ff;
   logic [YW-1:0]             s1_y_ff;
   logic                      s2_valid_ff, s2_we_ff;
   logic [AW-1:0]             s2_addr_ff;
   logic                      s3_valid_ff;
   logic [COLOR_W-1:0]        result_ff;

   logic signed [OFF_W-1:0]   half_s, half_n;
   logic signed [CELL_W-1:0]  cur_x, cur_y;
   logic signed [SQ_W-1:0]    dxe, dye, he, dist_sq, lim;
   logic                      keep, in_x, in_y, sweeping;
   logic [PW-1:0]             addr_full;
   logic                      ram_we;
   logic [AW-1:0]             ram_addr;
   logic [COLOR_W-1:0]        ram_wdata, ram_rdata;

   always_comb begin
      half_s = signed'({1'b0, op_ff.half});
      half_n = signed'({1'b0, op_in.half});
      cur_x  = CELL_W'(op_ff.cx) + CELL_W'(dx_ff);
      cur_y  = CELL_W'(op_ff.cy) + CELL_W'(dy_ff);
      dxe    = SQ_W'(dx_ff);
      dye    = SQ_W'(dy_ff);
      he     = SQ_W'(half_s);
      dist_sq = dxe * dxe + dye * dye;
      lim    = he * he + he;
      keep   = !op_ff.brush_round || (dist_sq <= lim);
      in_x   = !cur_x[CELL_W-1] && (cur_x[CELL_W-2:0] < (CELL_W-1)'(eff_w));
      in_y   = !cur_y[CELL_W-1] && (cur_y[CELL_W-2:0] < (CELL_W-1)'(eff_h));
      addr_full = PW'(s1_y_ff) * PW'(eff_w) + PW'(s1_x_ff);

      sweeping  = (state_ff == B_INIT) || (state_ff == B_CLEAR);
      ram_we    = sweeping || (s2_valid_ff && s2_we_ff);
      ram_addr  = sweeping ? sweep_ff : s2_addr_ff;
      ram_wdata = (state_ff == B_INIT) ? COLOR_WHITE : op_ff.color;

      op_pop    = (state_ff == B_IDLE) && !op_empty;
      rsp_push  = (state_ff == B_RESULT) && !rsp_full;
      rsp_data  = result_ff;
      init_busy = (state_ff == B_INIT);
   end

   bsf_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= B_INIT;
         sweep_ff    <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         // cell pipeline: bounds check, address, store access
         s1_valid_ff <= (state_ff == B_RUN) && keep && in_x && in_y;
         s1_we_ff    <= (op_ff.kind != CMD_GET);
         s1_x_ff     <= cur_x[XW-1:0];
         s1_y_ff     <= cur_y[YW-1:0];
         s2_valid_ff <= s1_valid_ff;
         s2_we_ff    <= s1_we_ff;
         s2_addr_ff  <= addr_full[AW-1:0];
         s3_valid_ff <= s2_valid_ff && !s2_we_ff;
         if (s3_valid_ff) begin
            result_ff <= ram_rdata;
         end

         unique case (state_ff)
            B_INIT, B_CLEAR: begin
               if (sweep_ff == AW'(DEPTH - 1)) begin
                  sweep_ff <= '0;
                  state_ff <= (state_ff == B_INIT) ? B_IDLE : B_RESULT;
               end else begin
                  sweep_ff <= sweep_ff + AW'(1);
               end
            end
            B_IDLE: begin
               if (!op_empty) begin
                  op_ff     <= op_in;
                  dx_ff     <= -half_n;
                  dy_ff     <= -half_n;
                  result_ff <= '0;
                  state_ff  <= (op_in.kind == CMD_CLEAR) ? B_CLEAR : B_RUN;
               end
            end
            B_RUN: begin
               // advance along the row, then to the next row
               if (dx_ff == half_s) begin
                  dx_ff <= -half_s;
                  if (dy_ff == half_s) begin
                     drain_ff <= 2'd2;
                     state_ff <= B_DRAIN;
                  end else begin
                     dy_ff <= dy_ff + OFF_W'(1);
                  end
               end else begin
                  dx_ff <= dx_ff + OFF_W'(1);
               end
            end
            B_DRAIN: begin
               drain_ff <= drain_ff - 2'd1;
               if (drain_ff == 2'd0) begin
                  state_ff <= B_RESULT;
               end
            end
            B_RESULT: begin
               if (!rsp_full) begin
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/brush_stamp_framebuffer.sv */
// Brush stamp frame store, top level: configuration registers, front end,
// command queue, back end and result queue. Depends on bsf_pkg and submodules.
// A paint makes two pointer divisions, then steps one brush cell per cycle;
// a clear sweeps every store word. Reset (synchronous, active high) sweeps
// every store word to white, one word per cycle, with req_full held high
// meanwhile.
`default_nettype none

module brush_stamp_framebuffer #(
   parameter int MAX_COLUMNS = 64,
   parameter int MAX_ROWS    = 64,
   parameter int MAX_BRUSH   = 31
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request transactions
   input  wire logic                        req_push,
   output logic                             req_full,
   input  wire logic [1:0]                  req_command,
   input  wire logic signed [15:0]          req_pointer_x,
   input  wire logic signed [15:0]          req_pointer_y,
   input  wire logic signed [15:0]          req_view_offset_x,
   input  wire logic signed [15:0]          req_view_offset_y,
   input  wire logic signed [15:0]          req_cell_x,
   input  wire logic signed [15:0]          req_cell_y,
   input  wire logic [31:0]                 req_color,
   input  wire logic [4:0]                  req_brush_size,
   input  wire logic                        req_brush_round,
   // response transactions
   output logic                             rsp_empty,
   input  wire logic                        rsp_pop,
   output logic [31:0]                      rsp_read_color,
   // configuration writes
   input  wire logic                        csr_write,
   input  wire logic [1:0]                  csr_index,
   input  wire logic [bsf_pkg::CSR_W-1:0]   csr_data
);
   import bsf_pkg::*;

   localparam int EW = $clog2(MAX_COLUMNS + 1);
   localparam int EH = $clog2(MAX_ROWS + 1);
   localparam int OPW = $bits(op_type);

   logic [CSR_W-1:0] canvas_width_ff, canvas_height_ff, cell_size_ff;
   logic [EW-1:0]    eff_w;
   logic [EH-1:0]    eff_h;
   logic [CSR_W-1:0] cell_div;

   logic             front_full, init_busy;
   logic             op_push, op_pop, op_full, op_empty;
   op_type           op_wr, op_rd;
   logic [OPW-1:0]   op_rd_bits;
   logic             rsp_push, rsp_full;
   logic [COLOR_W-1:0] rsp_data;

   // Hold the configuration; unknown indexes write nothing.
   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_width_ff  <= CSR_W'(32);
         canvas_height_ff <= CSR_W'(32);
         cell_size_ff     <= CSR_W'(8);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_CANVAS_WIDTH:  canvas_width_ff  <= csr_data;
            CSR_CANVAS_HEIGHT: canvas_height_ff <= csr_data;
            CSR_CELL_SIZE:     cell_size_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // Saturate the canvas to the store size; a zero cell size acts as one.
   always_comb begin
      eff_w = (32'(canvas_width_ff) > 32'(MAX_COLUMNS)) ? EW'(MAX_COLUMNS)
                                                        : EW'(canvas_width_ff);
      eff_h = (32'(canvas_height_ff) > 32'(MAX_ROWS)) ? EH'(MAX_ROWS)
                                                      : EH'(canvas_height_ff);
      cell_div = (cell_size_ff == '0) ? CSR_W'(1) : cell_size_ff;
      // no transaction enters while the reset sweep runs
      req_full = front_full || init_busy;
      op_rd    = op_type'(op_rd_bits);
   end

   bsf_front #(
      .MAX_BRUSH (MAX_BRUSH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (req_push && !init_busy),
      .full              (front_full),
      .req_command       (req_command),
      .req_pointer_x     (req_pointer_x),
      .req_pointer_y     (req_pointer_y),
      .req_view_offset_x (req_view_offset_x),
      .req_view_offset_y (req_view_offset_y),
      .req_cell_x        (req_cell_x),
      .req_cell_y        (req_cell_y),
      .req_color         (req_color),
      .req_brush_size    (req_brush_size),
      .req_brush_round   (req_brush_round),
      .cell_div          (cell_div),
      .op_push           (op_push),
      .op_out            (op_wr),
      .op_full           (op_full)
   );

   // Decouple classification from execution.
   bsf_queue #(
      .WIDTH (OPW),
      .DEPTH (2)
   ) u_op_queue (
      .clock (clock),
      .reset (reset),
      .push  (op_push),
      .wdata (op_wr),
      .pop   (op_pop),
      .rdata (op_rd_bits),
      .full  (op_full),
      .empty (op_empty)
   );

   bsf_back #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .eff_w     (eff_w),
      .eff_h     (eff_h),
      .op_empty  (op_empty),
      .op_in     (op_rd),
      .op_pop    (op_pop),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_data),
      .rsp_full  (rsp_full),
      .init_busy (init_busy)
   );

   // Hold finished results until the consumer pops them.
   bsf_queue #(
      .WIDTH (COLOR_W),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_data),
      .pop   (rsp_pop),
      .rdata (rsp_read_color),
      .full  (rsp_full),
      .empty (rsp_empty)
   );

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for brush_stamp_framebuffer: a scoreboard class
// mirrors the cell store and predicts read_color for every request.
// Depends on bsf_pkg and the brush_stamp_framebuffer RTL; nothing else.
`timescale 1ns / 100ps

module tb;
   import bsf_pkg::*;

   localparam int MAX_COLUMNS  = 64;
   localparam int MAX_ROWS     = 64;
   localparam int MAX_BRUSH    = 31;
   localparam int STORE_DEPTH  = MAX_COLUMNS * MAX_ROWS;
   // index 3 maps to no register; writes there must be ignored
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   // slowest legal run: up to 501 clears of the whole store, each behind stalls
   localparam int CYCLE_LIMIT  = 6_000_000;
   localparam int HOLD_CYCLES  = 2000;
   localparam int DRAIN_CYCLES = 100;

   // One request transaction as the sender presents it
   typedef struct {
      cmd_type            op;
      logic signed [15:0] pointer_x;
      logic signed [15:0] pointer_y;
      logic signed [15:0] view_offset_x;
      logic signed [15:0] view_offset_y;
      logic signed [15:0] cell_x;
      logic signed [15:0] cell_y;
      logic [31:0]        color;
      logic [4:0]         brush_size;
      logic               brush_round;
   } stamp_cmd_type;

   // Mirror of the canvas: holds its own copy of the store and registers,
   // and the read colours still owed by the block, oldest first.
   class canvas_scoreboard;
      logic [31:0]      cells [STORE_DEPTH];
      logic [CSR_W-1:0] canvas_width;
      logic [CSR_W-1:0] canvas_height;
      logic [CSR_W-1:0] cell_size;
      logic [31:0]      owed_colors [$];
      int               errors;

      function new();
         canvas_width  = 7'd32;
         canvas_height = 7'd32;
         cell_size     = 7'd8;
         errors        = 0;
         fill(COLOR_WHITE);
      endfunction

      function void write_register(logic [1:0] index, logic [CSR_W-1:0] value);
         case (index)
            CSR_CANVAS_WIDTH:  canvas_width  = value;
            CSR_CANVAS_HEIGHT: canvas_height = value;
            CSR_CELL_SIZE:     cell_size     = value;
            default: ;
         endcase
      endfunction

      // oversized registers saturate; zero leaves an empty canvas
      function int cols();
         return (canvas_width > MAX_COLUMNS) ? MAX_COLUMNS : int'(canvas_width);
      endfunction

      function int rows();
         return (canvas_height > MAX_ROWS) ? MAX_ROWS : int'(canvas_height);
      endfunction

      function int pitch();
         return (cell_size == 0) ? 1 : int'(cell_size);
      endfunction

      function bit on_canvas(int x, int y);
         return x >= 0 && x < cols() && y >= 0 && y < rows();
      endfunction

      function void fill(logic [31:0] color);
         foreach (cells[i]) cells[i] = color;
      endfunction

      function void put_cell(int x, int y, logic [31:0] color);
         if (on_canvas(x, y)) cells[y * cols() + x] = color;
      endfunction

      function int floor_quotient(int a, int b);
         int q;
         q = a / b;
         if (a % b != 0 && a < 0) q--;
         return q;
      endfunction

      function void note_command(stamp_cmd_type c);
         int          step, cx, cy, half, dx, dy;
         logic [31:0] read_color;
         read_color = '0;
         case (c.op)
            CMD_PAINT: begin
               step = pitch();
               cx   = floor_quotient(int'(c.pointer_x) - int'(c.view_offset_x), step);
               cy   = floor_quotient(int'(c.pointer_y) - int'(c.view_offset_y), step);
               // a 5-bit size never exceeds the brush limit
               half = int'(c.brush_size) / 2;
               for (dy = -half; dy <= half; dy++)
                  for (dx = -half; dx <= half; dx++)
                     if (!c.brush_round || dx * dx + dy * dy <= half * half + half)
                        put_cell(cx + dx, cy + dy, c.color);
            end
            CMD_SET: put_cell(int'(c.cell_x), int'(c.cell_y), c.color);
            CMD_GET: begin
               if (on_canvas(int'(c.cell_x), int'(c.cell_y)))
                  read_color = cells[int'(c.cell_y) * cols() + int'(c.cell_x)];
            end
            CMD_CLEAR: fill(c.color);
         endcase
         owed_colors.push_back(read_color);
      endfunction

      function void check_read_color(logic [31:0] actual);
         logic [31:0] expected_color;
         if (owed_colors.size() == 0) begin
            $error("read_color: expected nothing, actual %h", actual);
            errors++;
            return;
         end
         expected_color = owed_colors.pop_front();
         if (actual !== expected_color) begin
            $error("read_color: expected %h, actual %h", expected_color, actual);
            errors++;
         end
      endfunction

      function int owed();
         return owed_colors.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [1:0]         req_command = CMD_GET;
   logic signed [15:0] req_pointer_x = '0;
   logic signed [15:0] req_pointer_y = '0;
   logic signed [15:0] req_view_offset_x = '0;
   logic signed [15:0] req_view_offset_y = '0;
   logic signed [15:0] req_cell_x = '0;
   logic signed [15:0] req_cell_y = '0;
   logic [31:0]        req_color = '0;
   logic [4:0]         req_brush_size = '0;
   logic               req_brush_round = 1'b0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic [31:0]        rsp_read_color;
   logic               csr_write = 1'b0;
   logic [1:0]         csr_index = CSR_CANVAS_WIDTH;
   logic [CSR_W-1:0]   csr_data = '0;

   canvas_scoreboard sb = new();

   int          idle_pct = 0;       // chance in 100 that the sender idles a cycle
   int          stall_pct = 0;      // chance in 100 that the receiver stalls a cycle
   logic        hold_request = 1'b0;
   logic        hold_taken = 1'b0;
   int          hold_left = 0;
   int unsigned cycle_count = 0;

   brush_stamp_framebuffer #(
      .MAX_COLUMNS(MAX_COLUMNS),
      .MAX_ROWS(MAX_ROWS),
      .MAX_BRUSH(MAX_BRUSH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_command(req_command),
      .req_pointer_x(req_pointer_x),
      .req_pointer_y(req_pointer_y),
      .req_view_offset_x(req_view_offset_x),
      .req_view_offset_y(req_view_offset_y),
      .req_cell_x(req_cell_x),
      .req_cell_y(req_cell_y),
      .req_color(req_color),
      .req_brush_size(req_brush_size),
      .req_brush_round(req_brush_round),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_read_color(rsp_read_color),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog: a hung handshake or a lost result ends up here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("brush_stamp_framebuffer test failed");
         $finish;
      end
   end

   // Receiver: check each popped transaction against the oldest owed colour,
   // then decide whether to pop on the next edge. A single long hold-off,
   // counted here, lets the request side back up until req_full rises.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         sb.check_read_color(rsp_read_color);
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_pop    <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_pop   <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Offer one transaction, idling at random first, and hold it until taken.
   // The scoreboard is told in this process, so a settle check never misses it.
   task automatic send_command(input stamp_cmd_type c);
      while ($urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push          <= 1'b1;
      req_command       <= c.op;
      req_pointer_x     <= c.pointer_x;
      req_pointer_y     <= c.pointer_y;
      req_view_offset_x <= c.view_offset_x;
      req_view_offset_y <= c.view_offset_y;
      req_cell_x        <= c.cell_x;
      req_cell_y        <= c.cell_y;
      req_color         <= c.color;
      req_brush_size    <= c.brush_size;
      req_brush_round   <= c.brush_round;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.note_command(c);
   endtask

   // Drain every owed result so that registers change only while idle.
   task automatic settle();
      while (sb.owed() != 0) @(posedge clock);
   endtask

   // Write all three registers, preceded by a stray write to the unused index.
   task automatic program_canvas(input int width_value, input int height_value,
                                 input int size_value);
      logic [1:0]       index_list [4];
      logic [CSR_W-1:0] value_list [4];
      index_list = '{CSR_UNUSED, CSR_CANVAS_WIDTH, CSR_CANVAS_HEIGHT, CSR_CELL_SIZE};
      value_list = '{7'($urandom), 7'(width_value), 7'(height_value), 7'(size_value)};
      for (int i = 0; i < 4; i++) begin
         csr_write <= 1'b1;
         csr_index <= index_list[i];
         csr_data  <= value_list[i];
         @(posedge clock);
         sb.write_register(index_list[i], value_list[i]);
      end
      csr_write <= 1'b0;
   endtask

   function automatic stamp_cmd_type make_command(cmd_type op, int px, int py, int ox,
                                                  int oy, int cx, int cy,
                                                  logic [31:0] color, int size,
                                                  bit round);
      stamp_cmd_type c;
      c.op            = op;
      c.pointer_x     = 16'(px);
      c.pointer_y     = 16'(py);
      c.view_offset_x = 16'(ox);
      c.view_offset_y = 16'(oy);
      c.cell_x        = 16'(cx);
      c.cell_y        = 16'(cy);
      c.color         = color;
      c.brush_size    = 5'(size);
      c.brush_round   = round;
      return c;
   endfunction

   // Mostly well-formed: coordinates near the canvas, brushes mostly small.
   // The rest is raw 16-bit noise. cell_heavy favours cheap set/get traffic.
   function automatic stamp_cmd_type random_command(bit cell_heavy);
      stamp_cmd_type c;
      int            pick, width_now, height_now, step, org;
      width_now  = sb.cols();
      height_now = sb.rows();
      step       = sb.pitch();
      c.pointer_x     = 16'($urandom);
      c.pointer_y     = 16'($urandom);
      c.view_offset_x = 16'($urandom);
      c.view_offset_y = 16'($urandom);
      c.cell_x        = 16'($urandom);
      c.cell_y        = 16'($urandom);
      c.color         = $urandom;
      c.brush_size    = 5'($urandom);
      c.brush_round   = 1'($urandom);
      pick = int'($urandom_range(99));
      if (cell_heavy)
         c.op = (pick < 10) ? CMD_PAINT : (pick < 55) ? CMD_SET : CMD_GET;
      else
         c.op = (pick < 40) ? CMD_PAINT : (pick < 65) ? CMD_SET :
                (pick < 97) ? CMD_GET : CMD_CLEAR;
      if ($urandom_range(99) < 85) begin
         c.cell_x = 16'(int'($urandom_range(width_now + 3)) - 2);
         c.cell_y = 16'(int'($urandom_range(height_now + 3)) - 2);
         org = int'($urandom_range(32000)) - 16000;
         c.view_offset_x = 16'(org);
         c.pointer_x = 16'(org + (int'($urandom_range(width_now + 5)) - 3) * step
                           + int'($urandom_range(step - 1)));
         org = int'($urandom_range(32000)) - 16000;
         c.view_offset_y = 16'(org);
         c.pointer_y = 16'(org + (int'($urandom_range(height_now + 5)) - 3) * step
                           + int'($urandom_range(step - 1)));
         if ($urandom_range(99) < 80) c.brush_size = 5'($urandom_range(7));
      end
      return c;
   endfunction

   task automatic run_phase(input int width_value, input int height_value,
                            input int size_value, input int sender_idle,
                            input int receiver_stall, input int count,
                            input bit squeeze);
      settle();
      program_canvas(width_value, height_value, size_value);
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      if (squeeze) hold_request <= 1'b1;
      repeat (count) send_command(random_command(squeeze));
      req_push <= 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part on the reset canvas (32 x 32 cells, 8 pixels each).
      // Fresh store reads white; reads off the canvas read transparent.
      send_command(make_command(CMD_GET, 0, 0, 0, 0, 0, 0, '0, 0, 0));
      send_command(make_command(CMD_GET, 0, 0, 0, 0, 31, 31, '0, 0, 0));
      send_command(make_command(CMD_GET, 0, 0, 0, 0, 32, 0, '0, 0, 0));
      send_command(make_command(CMD_GET, 0, 0, 0, 0, 0, -1, '0, 0, 0));
      send_command(make_command(CMD_GET, 0, 0, 0, 0, -32768, 32767, '0, 0, 0));
      // set at the corners; writes off the canvas must be dropped
      send_command(make_command(CMD_SET, 0, 0, 0, 0, 0, 0, 32'h0000_0000, 0, 0));
      send_command(make_command(CMD_SET, 0, 0, 0, 0, 31, 31, 32'h1234_5678, 0, 0));
      send_command(make_command(CMD_SET, 0, 0, 0, 0, 32, 31, 32'hDEAD_BEEF, 0, 0));
      send_command(make_command(CMD_SET, 0, 0, 0, 0, 32767, -32768, 32'hA5A5_5A5A, 0, 0));
      send_command(make_command(CMD_GET, 0, 0, 0, 0, 0, 0, '0, 0, 0));
      send_command(make_command(CMD_GET, 0, 0, 0, 0, 31, 31, '0, 0, 0));
      // single-cell brush, then a brush centred left of the canvas (floor division)
      send_command(make_command(CMD_PAINT, 3, 3, 0, 0, 0, 0, 32'hFF00_00FF, 0, 0));
      send_command(make_command(CMD_PAINT, -1, 9, 0, 0, 0, 0, 32'h00FF_00FF, 3, 0));
      // widest round and square brushes
      send_command(make_command(CMD_PAINT, 130, 130, 0, 0, 0, 0, 32'h0000_FFFF, 31, 1));
      send_command(make_command(CMD_PAINT, 0, 0, -44, -44, 0, 0, 32'h8080_8080, 30, 0));
      // pointer and offset at opposite extremes: centre far off the canvas
      send_command(make_command(CMD_PAINT, 32767, 32767, -32768, -32768, 0, 0,
                                32'h0F0F_0F0F, 31, 1));
      send_command(make_command(CMD_PAINT, -32768, -32768, 32767, 32767, 0, 0,
                                32'hF0F0_F0F0, 31, 0));
      send_command(make_command(CMD_PAINT, 231, 24, 0, 0, 0, 0, 32'h7777_0000, 5, 1));
      // probe the rim of the wide round brush and the small one's corner
      send_command(make_command(CMD_GET, 0, 0, 0, 0, 16, 1, '0, 0, 0));
      send_command(make_command(CMD_GET, 0, 0, 0, 0, 1, 16, '0, 0, 0));
      send_command(make_command(CMD_GET, 0, 0, 0, 0, 30, 1, '0, 0, 0));
      send_command(make_command(CMD_GET, 0, 0, 0, 0, 26, 1, '0, 0, 0));
      // clear fills everything; off-canvas still reads transparent
      send_command(make_command(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 32'h00FF_00FF, 0, 0));
      send_command(make_command(CMD_GET, 0, 0, 0, 0, 5, 5, '0, 0, 0));
      send_command(make_command(CMD_GET, 0, 0, 0, 0, 63, 63, '0, 0, 0));
      req_push <= 1'b0;

      // Random phases: width, height, cell size, sender idle, receiver stall
      run_phase(32, 32, 8, 0, 0, 60, 1'b0);
      run_phase(64, 64, 1, 65, 0, 100, 1'b0);
      run_phase(1, 1, 64, 0, 65, 80, 1'b0);
      run_phase(0, 5, 0, 32, 32, 50, 1'b0);       // empty canvas, zero cell size
      run_phase(127, 100, 127, 0, 0, 60, 1'b0);   // oversized registers saturate
      run_phase(17, 9, 3, 0, 0, 80, 1'b1);        // receiver holds off, queue fills
      run_phase(64, 1, 5, 32, 32, 80, 1'b0);
      run_phase(5, 64, 64, 32, 0, 70, 1'b0);

      // Drain, then give a stray late result time to show up.
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("brush_stamp_framebuffer test passed");
      else
         $display("brush_stamp_framebuffer test failed");
      $finish;
   end

endmodule
